[rtl/sync_length_xor_frame_finder_unit_defines.svh]
// Assertion macros shared by the frame finder modules.
// Each macro expects clk and rst_n in scope.
`ifndef SYNC_LENGTH_XOR_FRAME_FINDER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define SFIND_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfind: assertion failed");

// Next-cycle implication, off while reset is held
`define SFIND_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfind: assertion failed");

`endif

[rtl/sfind_pkg.sv]
package sfind_pkg;

  // Number of candidate cells in the row
  localparam int unsigned NUM_CELLS = 16;
  localparam int unsigned CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  localparam logic [7:0] SYNC_RESET    = 8'h55;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd3;

  // Result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DROP  = 1'b1;

  // Frame held by one cell
  typedef struct packed {
    logic [31:0] start;
    logic [7:0]  length;
  } sfind_frame_t;

  // What the cell row hands to the result drain on an accepted request
  typedef struct packed {
    logic                 fire;
    logic [NUM_CELLS-1:0] hit;
    logic                 drop;
    logic [31:0]          pos;
  } sfind_capture_t;

endpackage

[rtl/sfind_cell.sv]
module sfind_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            data_byte,
  input  logic                  stream_end,
  input  logic [7:0]            sync_value,
  input  logic [31:0]           pos,
  input  logic                  claim_in,
  output logic                  claim_out,
  output logic                  hit,
  output sfind_pkg::sfind_frame_t frame
);

  logic        open_r, open_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  parity_r, parity_nxt;
  logic [31:0] start_r, start_nxt;
  sfind_pkg::sfind_frame_t frame_r, frame_nxt;
  logic [7:0]  idx;
  logic        open_after;

  assign idx = count_r + 8'd1;

  // Consume the byte, then take the open slot if the claim reaches a free cell
  always_comb begin
    open_nxt   = open_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    parity_nxt = parity_r;
    start_nxt  = start_r;
    frame_nxt  = frame_r;
    hit        = 1'b0;
    if (fire && open_r) begin
      count_nxt = idx;
      if (idx == 8'd1) begin
        length_nxt = data_byte;
        parity_nxt = parity_r ^ data_byte;
        if (data_byte < sfind_pkg::MIN_FRAME_LEN) begin
          open_nxt = 1'b0;
        end
      end else if (({1'b0, idx} + 9'd1) < {1'b0, length_r}) begin
        parity_nxt = parity_r ^ data_byte;
      end else begin
        hit      = (data_byte == parity_r);
        open_nxt = 1'b0;
        // Hold the finished frame apart from the candidate registers
        if (hit) begin
          frame_nxt.start  = start_r;
          frame_nxt.length = length_r;
        end
      end
    end
    open_after = open_nxt;
    claim_out  = claim_in & open_after;
    if (fire && claim_in && !open_after) begin
      open_nxt   = 1'b1;
      count_nxt  = 8'd0;
      length_nxt = 8'd0;
      parity_nxt = sync_value;
      start_nxt  = pos;
    end
    // Close everything at end of stream
    if (fire && stream_end) begin
      open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r  <= count_nxt;
    length_r <= length_nxt;
    parity_r <= parity_nxt;
    start_r  <= start_nxt;
    frame_r  <= frame_nxt;
  end

  assign frame = frame_r;

endmodule

[rtl/sfind_drain.sv]
`include "sync_length_xor_frame_finder_unit_defines.svh"

module sfind_drain (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sfind_pkg::sfind_capture_t cap,
  input  sfind_pkg::sfind_frame_t frames [sfind_pkg::NUM_CELLS],
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_result_kind,
  output logic [31:0]             out_frame_start,
  output logic [7:0]              out_frame_length,
  output logic                    out_run_last
);

  logic [sfind_pkg::NUM_CELLS-1:0]  pend_r, pend_nxt;
  logic                             drop_pend_r, drop_pend_nxt;
  logic [31:0]                      drop_pos_r, drop_pos_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             kind_r, kind_nxt;
  logic [31:0]                      start_r, start_nxt;
  logic [7:0]                       length_r, length_nxt;
  logic                             last_r, last_nxt;
  logic                             out_free;
  logic [sfind_pkg::CELL_IDX_W-1:0] sel;
  logic [sfind_pkg::NUM_CELLS-1:0]  sel_mask;

  assign out_free = !out_valid_r || out_ready;
  assign busy     = (pend_r != '0) || drop_pend_r;

  // Pick the lowest pending cell
  always_comb begin
    sel      = '0;
    sel_mask = '0;
    for (int i = sfind_pkg::NUM_CELLS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = sfind_pkg::CELL_IDX_W'(i);
      end
    end
    sel_mask[sel] = 1'b1;
  end

  // Capture new results, load the output register one request at a time
  always_comb begin
    pend_nxt      = pend_r;
    drop_pend_nxt = drop_pend_r;
    drop_pos_nxt  = drop_pos_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    start_nxt     = start_r;
    length_nxt    = length_r;
    last_nxt      = last_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (pend_r != '0) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = sfind_pkg::KIND_FRAME;
        start_nxt     = frames[sel].start;
        length_nxt    = frames[sel].length;
        last_nxt      = ((pend_r & ~sel_mask) == '0) && !drop_pend_r;
        pend_nxt      = pend_r & ~sel_mask;
      end else if (drop_pend_r) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = sfind_pkg::KIND_DROP;
        start_nxt     = drop_pos_r;
        length_nxt    = 8'd0;
        last_nxt      = 1'b1;
        drop_pend_nxt = 1'b0;
      end
    end
    if (cap.fire) begin
      pend_nxt      = cap.hit;
      drop_pend_nxt = cap.drop;
      drop_pos_nxt  = cap.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      drop_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      drop_pend_r <= drop_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_pos_r <= drop_pos_nxt;
    kind_r     <= kind_nxt;
    start_r    <= start_nxt;
    length_r   <= length_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_frame_start  = start_r;
  assign out_frame_length = length_r;
  assign out_run_last     = last_r;

  `SFIND_ASSERT_IMP(a_drop_closes_run, out_valid_r && kind_r == sfind_pkg::KIND_DROP, last_r && length_r == 8'd0)
  `SFIND_ASSERT_NXT(a_pend_one_per_load, out_free && pend_r != '0, $countones(pend_r) == $countones($past(pend_r)) - 1)
  `SFIND_ASSERT_IMP(a_no_capture_busy, busy, !cap.fire)

endmodule

[rtl/sync_length_xor_frame_finder_unit.sv]
// Sync / length / XOR-checksum frame finder.
// Input channel (in_valid/in_ready): one stream byte per request with a
// stream-end flag. Every byte equal to the sync register opens a candidate in
// the lowest free cell of a row of sfind_pkg::NUM_CELLS cells; all open cells
// take each byte in the same cycle. A frame whose checksum matches yields a
// result (start offset, length N); a sync byte with no free cell yields a
// drop result. Results of one byte come in cell order, drop last, with
// out_run_last on the final one.
// Config: cfg_wr_en/cfg_wr_data write the sync byte (reset 0x55); write only
// while idle.
// Timing: a byte with no result leaves in_ready high; one with results holds
// it low until the result drain is empty, as the drain hands out one request
// per cycle while its output register is free. A result goes through the
// drain's pending and output registers. If the receiver stalls, the output
// register holds and the drain waits; a byte with no result is still taken.
// Reset: all cells close, stream offset returns to 0, outputs go invalid.
`include "sync_length_xor_frame_finder_unit_defines.svh"

module sync_length_xor_frame_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [31:0] out_frame_start,
  output logic [7:0]  out_frame_length,
  output logic        out_run_last,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0]                    sync_r, sync_nxt;
  logic [31:0]                   pos_r, pos_nxt;
  logic                          in_fire;
  logic                          busy;
  logic [sfind_pkg::NUM_CELLS:0] claim;
  logic [sfind_pkg::NUM_CELLS-1:0] hit;
  logic [sfind_pkg::NUM_CELLS-1:0] take;
  sfind_pkg::sfind_frame_t       frames [sfind_pkg::NUM_CELLS];
  sfind_pkg::sfind_capture_t     cap;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  // Hold the sync byte, advance the stream offset
  always_comb begin
    sync_nxt = cfg_wr_en ? cfg_wr_data : sync_r;
    pos_nxt  = in_fire ? pos_r + 32'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= sfind_pkg::SYNC_RESET;
      pos_r  <= '0;
    end else begin
      sync_r <= sync_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Claim token ripples along the row until a free cell takes it
  assign claim[0] = (in_data_byte == sync_r);
  assign take     = claim[sfind_pkg::NUM_CELLS-1:0] & ~claim[sfind_pkg::NUM_CELLS:1];

  for (genvar g = 0; g < sfind_pkg::NUM_CELLS; g++) begin : g_cell
    sfind_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .fire       (in_fire),
      .data_byte  (in_data_byte),
      .stream_end (in_stream_end),
      .sync_value (sync_r),
      .pos        (pos_r),
      .claim_in   (claim[g]),
      .claim_out  (claim[g+1]),
      .hit        (hit[g]),
      .frame      (frames[g])
    );
  end

  assign cap.fire = in_fire;
  assign cap.hit  = hit;
  assign cap.drop = claim[sfind_pkg::NUM_CELLS];
  assign cap.pos  = pos_r;

  sfind_drain u_drain (
    .clk              (clk),
    .rst_n            (rst_n),
    .cap              (cap),
    .frames           (frames),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_frame_start  (out_frame_start),
    .out_frame_length (out_frame_length),
    .out_run_last     (out_run_last)
  );

  `SFIND_ASSERT_IMP(a_one_cell_claimed, 1'b1, $onehot0(take))
  `SFIND_ASSERT_IMP(a_drop_needs_sync, claim[sfind_pkg::NUM_CELLS], in_data_byte == sync_r)
  `SFIND_ASSERT_NXT(a_results_block_input, in_fire && hit != '0, !in_ready)

endmodule

[tb/sfind_frame_checker.sv]
module sfind_frame_checker
  import sfind_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [31:0] out_frame_start,
  input  logic [7:0]  out_frame_length,
  input  logic        out_run_last,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int          fail_count,
  output int          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic        last;
  } frame_report_t;

  // Reports still owed by the block, oldest first
  frame_report_t owed_q[$];

  // Shadow copy of the sync register and the candidate row
  logic [7:0]  sync_byte;
  logic        cell_busy   [NUM_CELLS];
  logic [7:0]  cell_seen   [NUM_CELLS];
  logic [7:0]  cell_len    [NUM_CELLS];
  logic [7:0]  cell_xor    [NUM_CELLS];
  logic [31:0] cell_origin [NUM_CELLS];
  logic [31:0] byte_offset;

  // Advance every open candidate by one byte and queue the reports it causes
  function automatic void scan_byte(input logic [7:0] b, input logic eos);
    int unsigned seen;
    int          queued_before;
    bit          placed;
    frame_report_t rep;
    queued_before = owed_q.size();
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (!cell_busy[i]) continue;
      seen = int'(cell_seen[i]) + 1;
      cell_seen[i] = 8'(seen);
      if (seen == 1) begin
        cell_len[i] = b;
        cell_xor[i] = cell_xor[i] ^ b;
        if (b < MIN_FRAME_LEN) cell_busy[i] = 1'b0;
      end else if (seen + 1 < int'(cell_len[i])) begin
        cell_xor[i] = cell_xor[i] ^ b;
      end else begin
        if (b == cell_xor[i]) begin
          rep.kind   = KIND_FRAME;
          rep.start  = cell_origin[i];
          rep.length = cell_len[i];
          rep.last   = 1'b0;
          owed_q.push_back(rep);
        end
        cell_busy[i] = 1'b0;
      end
    end
    // Open a new candidate in the lowest free cell, or report a drop
    if (b == sync_byte) begin
      placed = 1'b0;
      for (int i = 0; i < NUM_CELLS && !placed; i++) begin
        if (!cell_busy[i]) begin
          cell_busy[i]   = 1'b1;
          cell_seen[i]   = 8'd0;
          cell_len[i]    = 8'd0;
          cell_xor[i]    = sync_byte;
          cell_origin[i] = byte_offset;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        rep.kind   = KIND_DROP;
        rep.start  = byte_offset;
        rep.length = 8'd0;
        rep.last   = 1'b0;
        owed_q.push_back(rep);
      end
    end
    if (eos) begin
      for (int i = 0; i < NUM_CELLS; i++) cell_busy[i] = 1'b0;
    end
    if (owed_q.size() > queued_before) owed_q[owed_q.size() - 1].last = 1'b1;
    byte_offset = byte_offset + 32'd1;
  endfunction

  // Compare results, track config writes and predict on each request
  always @(posedge clk) begin
    frame_report_t exp_rep;
    if (!rst_n) begin
      sync_byte   = SYNC_RESET;
      byte_offset = 32'd0;
      for (int i = 0; i < NUM_CELLS; i++) begin
        cell_busy[i]   = 1'b0;
        cell_seen[i]   = 8'd0;
        cell_len[i]    = 8'd0;
        cell_xor[i]    = 8'd0;
        cell_origin[i] = 32'd0;
      end
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: kind %0d start %0h length %0d", out_result_kind,
                 out_frame_start, out_frame_length);
          fail_count++;
        end else begin
          exp_rep = owed_q.pop_front();
          if (out_result_kind !== exp_rep.kind) begin
            $error("result_kind: expected %0d, got %0d", exp_rep.kind, out_result_kind);
            fail_count++;
          end
          if (out_frame_start !== exp_rep.start) begin
            $error("frame_start: expected %0h, got %0h", exp_rep.start, out_frame_start);
            fail_count++;
          end
          if (out_frame_length !== exp_rep.length) begin
            $error("frame_length: expected %0d, got %0d", exp_rep.length, out_frame_length);
            fail_count++;
          end
          if (out_run_last !== exp_rep.last) begin
            $error("run_last: expected %0d, got %0d", exp_rep.last, out_run_last);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) sync_byte = cfg_wr_data;
      if (in_valid && in_ready) scan_byte(in_data_byte, in_stream_end);
    end
    results_owed = owed_q.size();
  end

endmodule

[tb/sync_length_xor_frame_finder_unit_tb.sv]
module sync_length_xor_frame_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfind_pkg::*;

  typedef logic [7:0] byte_seq_t[$];

  bit          clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_stream_end;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [31:0] out_frame_start;
  logic [7:0]  out_frame_length;
  logic        out_run_last;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  int          fail_count;
  int          results_owed;
  int          bytes_sent;
  bit          steady;
  logic [7:0]  sync_now;

  sync_length_xor_frame_finder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_frame_start  (out_frame_start),
    .out_frame_length (out_frame_length),
    .out_run_last     (out_run_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  sfind_frame_checker frame_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_frame_start  (out_frame_start),
    .out_frame_length (out_frame_length),
    .out_run_last     (out_run_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .results_owed     (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short ones, a rare long one; none while steady
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Payload byte, biased towards the sync value and the extremes
  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return sync_now;
    if (r < 15) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Stall the result side at random, with bursts of steady ready
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready <= 1'b1;
        run_left--;
      end else begin
        stall_left = gap_len();
        run_left = $urandom_range(1, 12);
      end
    end
  end

  // Offer one byte request; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_stream_end <= e;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send sync, length, payload and checksum; short lengths stop after the length
  task automatic push_frame(input logic [7:0] n, input byte_seq_t pay, input bit spoil,
                            input bit end_at_close);
    logic [7:0] chk;
    chk = sync_now ^ n;
    push_byte(sync_now, 1'b0);
    push_byte(n, (n < MIN_FRAME_LEN) && end_at_close);
    if (n >= MIN_FRAME_LEN) begin
      foreach (pay[k]) begin
        push_byte(pay[k], 1'b0);
        chk = chk ^ pay[k];
      end
      if (spoil) chk = chk ^ 8'($urandom_range(1, 255));
      push_byte(chk, end_at_close);
    end
  endtask

  // Drop valid, wait for every owed result, then let the row go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sync_now = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random mix of frames, broken sequences, sync bursts and noise
  task automatic random_traffic(input int target);
    int         goal;
    int         r;
    int         n;
    byte_seq_t  pay;
    goal = bytes_sent + target;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = $urandom_range(0, 99);
        if (n < 80) n = $urandom_range(3, 10);
        else if (n < 99) n = $urandom_range(11, 40);
        else n = $urandom_range(200, 255);
        pay = {};
        repeat (n - 3) pay.push_back(pick_payload());
        // nest a minimal frame inside the payload now and then
        if (n >= 6 && $urandom_range(0, 99) < 15) begin
          pay[0] = sync_now;
          pay[1] = 8'd3;
          pay[2] = sync_now ^ 8'd3;
        end
        push_frame(8'(n), pay, $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 10);
      end else if (r < 70) begin
        pay = {};
        push_frame(8'($urandom_range(0, 2)), pay, 1'b0, $urandom_range(0, 99) < 10);
      end else if (r < 78) begin
        // push a burst of sync bytes into the row, then maybe clear it
        repeat ($urandom_range(10, 20)) push_byte(sync_now, 1'b0);
        if ($urandom_range(0, 1) == 1) push_byte(pick_payload(), 1'b1);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 4)) push_byte(pick_payload(), $urandom_range(0, 99) < 5);
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    byte_seq_t pay;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_stream_end = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 8'h00;
    steady        = 1'b0;
    bytes_sent    = 0;
    sync_now      = SYNC_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: minimal frame, extremes, short lengths, bad checksum
    pay = {};
    push_frame(8'd3, pay, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_frame(8'd2, pay, 1'b0, 1'b0);
    push_frame(8'd0, pay, 1'b0, 1'b0);
    pay = {8'hAA};
    push_frame(8'd4, pay, 1'b1, 1'b0);
    // good frame closed by the stream end on its checksum
    pay = {8'hFF, 8'h00};
    push_frame(8'd5, pay, 1'b0, 1'b1);
    // frame nested inside another, both good
    pay = {sync_now, 8'd3, sync_now ^ 8'd3};
    push_frame(8'd6, pay, 1'b0, 1'b0);
    // stream end in the middle of a candidate
    push_byte(sync_now, 1'b0);
    push_byte(8'd7, 1'b0);
    push_byte(8'h11, 1'b1);
    push_byte(8'hFF, 1'b1);

    random_traffic(70);
    settle();
    write_sync(8'h00);
    random_traffic(70);
    settle();
    write_sync(8'hFF);
    random_traffic(70);
    settle();
    write_sync(8'($urandom_range(0, 255)));
    random_traffic(70);
    settle();
    write_sync(8'($urandom_range(3, 254)));
    random_traffic(70);
    settle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bail out if the run hangs
  initial begin
    #25ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/sfind_pkg.sv
rtl/sfind_cell.sv
rtl/sfind_drain.sv
rtl/sync_length_xor_frame_finder_unit.sv
tb/sfind_frame_checker.sv
tb/sync_length_xor_frame_finder_unit_tb.sv
